### rtl/core/stack_machine_instruction_executor_assert.svh
// assertion macros for the stack machine executor
`ifndef STACK_MACHINE_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_INSTRUCTION_EXECUTOR_ASSERT_SVH

// implication checked every cycle outside reset
`define SMX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/smx_pkg.sv
package smx_pkg;

   localparam int DataDepth    = 64;
   localparam int OperandDepth = 16;
   localparam int ProgramDepth = 256;

   localparam int DaW = $clog2(DataDepth);
   localparam int OaW = $clog2(OperandDepth);
   localparam int PcW = $clog2(ProgramDepth);
   localparam int SpW = DaW + 1;
   localparam int OtW = OaW + 1;

   localparam logic [3:0] KIND_LIT = 4'd1;
   localparam logic [3:0] KIND_OPR = 4'd2;
   localparam logic [3:0] KIND_LOD = 4'd3;
   localparam logic [3:0] KIND_STO = 4'd4;
   localparam logic [3:0] KIND_CAL = 4'd5;
   localparam logic [3:0] KIND_INC = 4'd6;
   localparam logic [3:0] KIND_JMP = 4'd7;
   localparam logic [3:0] KIND_JPC = 4'd8;
   localparam logic [3:0] KIND_SIO = 4'd9;

   localparam logic [31:0] OPR_RET = 32'd0;
   localparam logic [31:0] OPR_NEG = 32'd1;
   localparam logic [31:0] OPR_ADD = 32'd2;
   localparam logic [31:0] OPR_SUB = 32'd3;
   localparam logic [31:0] OPR_MUL = 32'd4;
   localparam logic [31:0] OPR_DIV = 32'd5;
   localparam logic [31:0] OPR_EQL = 32'd6;
   localparam logic [31:0] OPR_NEQ = 32'd7;
   localparam logic [31:0] OPR_LSS = 32'd8;
   localparam logic [31:0] OPR_LEQ = 32'd9;
   localparam logic [31:0] OPR_GTR = 32'd10;
   localparam logic [31:0] OPR_GEQ = 32'd11;
   localparam logic [31:0] OPR_AND = 32'd12;
   localparam logic [31:0] OPR_OR  = 32'd13;
   localparam logic [31:0] OPR_NOT = 32'd14;

   localparam logic [31:0] SIO_WRITE = 32'd1;
   localparam logic [31:0] SIO_READ  = 32'd2;
   localparam logic [31:0] SIO_HALT  = 32'd3;

   localparam logic [1:0] STATUS_RUN   = 2'd0;
   localparam logic [1:0] STATUS_HALT  = 2'd1;
   localparam logic [1:0] STATUS_FAULT = 2'd2;

   typedef struct packed {
      logic [3:0]         kind;
      logic [2:0]         level;
      logic signed [31:0] operand;
      logic signed [31:0] read_value;
   } req_type;

   typedef struct packed {
      logic [7:0]         next_address;
      logic               write_valid;
      logic signed [31:0] write_value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DECODE,
      ST_WALK_RD,
      ST_WALK_WAIT,
      ST_WALK_USE,
      ST_EXEC_RD,
      ST_EXEC_WAIT,
      ST_EXEC,
      ST_DIV,
      ST_CALL,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic clr_step;   // clear one data word
      logic walk_rd;    // issue walk read
      logic walk_use;   // follow static link
      logic exec_rd;    // issue operand/data read
      logic exec;       // evaluate and commit (divide after its iteration)
      logic div_start;
      logic div_step;
      logic call_step;  // write one call-frame word
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic halted;
      logic need_walk;
      logic walk_last;  // current hop is the last one
      logic walk_bad;
      logic is_div;     // valid division ready to iterate
      logic is_call;    // call passes checks
      logic div_done;
      logic call_done;
   } sts_type;

endpackage

### rtl/core/smx_ctrl.sv
module smx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  smx_pkg::sts_type  sts,
   output smx_pkg::cmd_type  cmd
);
   import smx_pkg::*;

   state_type state_ff, state_in;
   logic      out_free;

   assign out_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (sts.clr_done) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (sts.halted) state_in = ST_DONE;
            else if (sts.need_walk) state_in = ST_WALK_RD;
            else state_in = ST_EXEC_RD;
         end
         ST_WALK_RD:   state_in = ST_WALK_WAIT;
         ST_WALK_WAIT: state_in = ST_WALK_USE;
         ST_WALK_USE: begin
            if (sts.walk_bad || sts.walk_last) state_in = ST_EXEC_RD;
            else state_in = ST_WALK_RD;
         end
         ST_EXEC_RD:   state_in = ST_EXEC_WAIT;
         ST_EXEC_WAIT: begin
            if (sts.is_div) state_in = ST_DIV;
            else if (sts.is_call) state_in = ST_CALL;
            else state_in = ST_EXEC;
         end
         ST_DIV:       if (sts.div_done) state_in = ST_EXEC;
         ST_CALL:      if (sts.call_done) state_in = ST_DONE;
         ST_EXEC:      state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:     cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WALK_RD:   cmd.walk_rd = 1'b1;
         ST_WALK_USE:  cmd.walk_use = 1'b1;
         ST_EXEC_RD:   cmd.exec_rd = 1'b1;
         ST_EXEC_WAIT: cmd.div_start = sts.is_div;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_CALL:      cmd.call_step = 1'b1;
         ST_EXEC:      cmd.exec = 1'b1;
         ST_DONE:      cmd.out_load = out_free;
         default:      cmd = '0;
      endcase
   end

`include "stack_machine_instruction_executor_assert.svh"
   `SMX_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `SMX_ASSERT_NEXT(a_load_dec, clock, reset, cmd.load, state_ff == ST_DECODE, "load not followed by decode")
   `SMX_ASSERT_IMP(a_out_free, clock, reset, cmd.out_load, out_free, "result overwritten")
endmodule

### rtl/core/smx_path.sv
module smx_path (
   input  logic              clock,
   input  logic              reset,
   input  smx_pkg::req_type  req_data,
   input  smx_pkg::cmd_type  cmd,
   output smx_pkg::sts_type  sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smx_pkg::rsp_type  rsp_data
);
   import smx_pkg::*;

   logic [31:0] dmem [DataDepth];
   logic [31:0] omem [OperandDepth];

   req_type        req_ff;
   logic [PcW-1:0] pc_ff, pc_in;
   logic [DaW-1:0] bp_ff;
   logic [SpW-1:0] sp_ff;      // two's complement, -1 allowed
   logic [OtW-1:0] ot_ff;
   logic           halt_ff;
   logic [DaW-1:0] clr_ff;
   logic [2:0]     hops_ff;
   logic [DaW-1:0] base_ff;
   logic           bad_ff;
   logic [31:0]    drd_ff, ox_ff, oy_ff;
   logic [1:0]     cstep_ff;
   rsp_type        res_ff;
   rsp_type        out_ff;
   logic           rvalid_ff;

   // divider
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff;

   // decoded opcode
   logic [3:0]  kind;
   logic [31:0] opu;
   logic        is_opr;
   assign kind   = req_ff.kind;
   assign opu    = req_ff.operand;
   assign is_opr = kind == KIND_OPR;

   // data reads: walk uses base, exec uses computed address (bp+2 for return)
   logic [DaW-1:0] daddr;
   logic signed [33:0] eaddr;
   logic           eaddr_ok;
   assign eaddr    = $signed({2'b0, base_ff}) + $signed({{2{opu[31]}}, opu});
   assign eaddr_ok = eaddr >= 0 && eaddr < DataDepth;

   // return reads bp+1 and bp+2 (return address lands in drd)
   logic [DaW:0] bp1, bp2;
   assign bp1 = {1'b0, bp_ff} + 1'b1;
   assign bp2 = {1'b0, bp_ff} + 2'd2;
   logic ret_addr_ok;
   assign ret_addr_ok = bp2 < DataDepth;

   logic is_ret;
   assign is_ret = is_opr && opu == OPR_RET;
   assign daddr  = cmd.walk_rd ? base_ff : (is_ret ? bp2[DaW-1:0] : eaddr[DaW-1:0]);

   logic [31:0] retb_ff;

   logic [OaW-1:0] otm1, otm2;
   assign otm1 = OaW'(ot_ff - 1'b1);
   assign otm2 = OaW'(ot_ff - 2'd2);

   always_ff @(posedge clock) begin
      if (cmd.walk_rd || cmd.exec_rd) drd_ff <= dmem[daddr];
      if (cmd.exec_rd) begin
         retb_ff <= dmem[bp1[DaW-1:0]];
         ox_ff   <= omem[otm2];
         oy_ff   <= omem[otm1];
      end
   end

   // signed compare helpers
   logic signed [31:0] sx, sy;
   assign sx = ox_ff;
   assign sy = oy_ff;
   logic [63:0] prod;
   assign prod = ox_ff * oy_ff;

   logic has1, has2, room;
   assign has1 = ot_ff >= 1;
   assign has2 = ot_ff >= 2;
   assign room = ot_ff < OperandDepth;

   logic signed [33:0] inc_sum;
   assign inc_sum = $signed({{(34-SpW){sp_ff[SpW-1]}}, sp_ff}) + $signed({{2{opu[31]}}, opu});

   logic signed [SpW+1:0] sp3;
   assign sp3 = $signed({sp_ff[SpW-1], sp_ff[SpW-1], sp_ff}) + $signed((SpW+2)'(3));

   logic call_ok;
   assign call_ok = sp3 < DataDepth && !bad_ff;

   logic [31:0] divq;
   assign divq = dneg_ff ? (0 - dq_ff) : dq_ff;

   // evaluation
   logic           fault;
   logic [PcW-1:0] next;
   logic           wvalid;
   logic [31:0]    wval;
   logic           o_we;
   logic [OaW-1:0] o_wa;
   logic [31:0]    o_wd;
   logic [OtW-1:0] ot_n;
   logic           d_we;
   logic [DaW-1:0] d_wa;
   logic [31:0]    d_wd;
   logic [DaW-1:0] bp_n;
   logic [SpW-1:0] sp_n;
   logic           halt_n;
   logic [31:0]    bres;

   always_comb begin
      case (opu)
         OPR_ADD: bres = ox_ff + oy_ff;
         OPR_SUB: bres = ox_ff - oy_ff;
         OPR_MUL: bres = prod[31:0];
         OPR_DIV: bres = divq;
         OPR_EQL: bres = {31'd0, sx == sy};
         OPR_NEQ: bres = {31'd0, sx != sy};
         OPR_LSS: bres = {31'd0, sx < sy};
         OPR_LEQ: bres = {31'd0, sx <= sy};
         OPR_GTR: bres = {31'd0, sx > sy};
         OPR_GEQ: bres = {31'd0, sx >= sy};
         OPR_AND: bres = {31'd0, ox_ff == 32'd1 && oy_ff == 32'd1};
         default: bres = {31'd0, ox_ff == 32'd1 || oy_ff == 32'd1};
      endcase
   end

   always_comb begin
      fault  = 1'b0;
      next   = PcW'(pc_ff + 1'b1);
      wvalid = 1'b0;
      wval   = '0;
      o_we   = 1'b0;
      o_wa   = ot_ff[OaW-1:0];
      o_wd   = opu;
      ot_n   = ot_ff;
      d_we   = 1'b0;
      d_wa   = eaddr[DaW-1:0];
      d_wd   = oy_ff;
      bp_n   = bp_ff;
      sp_n   = sp_ff;
      halt_n = halt_ff;
      case (kind)
         KIND_LIT: begin
            if (!room) fault = 1'b1;
            else begin o_we = 1'b1; ot_n = ot_ff + 1'b1; end
         end
         KIND_OPR: begin
            if (opu == OPR_RET) begin
               if (!ret_addr_ok || $signed(retb_ff) < 0 || $signed(retb_ff) >= DataDepth)
                  fault = 1'b1;
               else begin
                  next = drd_ff[PcW-1:0];
                  sp_n = SpW'({1'b0, bp_ff} - 1'b1);
                  bp_n = retb_ff[DaW-1:0];
               end
            end else if (opu == OPR_NEG || opu == OPR_NOT) begin
               if (!has1) fault = 1'b1;
               else begin
                  o_we = 1'b1; o_wa = otm1;
                  o_wd = (opu == OPR_NEG) ? (0 - oy_ff) : {31'd0, oy_ff != 32'd1};
               end
            end else if (opu >= OPR_ADD && opu <= OPR_OR) begin
               if (!has2 || (opu == OPR_DIV && oy_ff == 0)) fault = 1'b1;
               else begin
                  o_we = 1'b1; o_wa = otm2; o_wd = bres; ot_n = ot_ff - 1'b1;
               end
            end else fault = 1'b1;
         end
         KIND_LOD, KIND_STO: begin
            if (bad_ff || !eaddr_ok) fault = 1'b1;
            else if (kind == KIND_LOD) begin
               if (!room) fault = 1'b1;
               else begin o_we = 1'b1; o_wd = drd_ff; ot_n = ot_ff + 1'b1; end
            end else begin
               if (!has1) fault = 1'b1;
               else begin d_we = 1'b1; ot_n = ot_ff - 1'b1; end
            end
         end
         KIND_CAL: begin
            if (!call_ok) fault = 1'b1;
            else begin
               next = opu[PcW-1:0];
               bp_n = DaW'(sp_ff + 1'b1);
            end
         end
         KIND_INC: begin
            if (inc_sum < -1 || inc_sum >= DataDepth) fault = 1'b1;
            else sp_n = inc_sum[SpW-1:0];
         end
         KIND_JMP: next = opu[PcW-1:0];
         KIND_JPC: begin
            if (!has1) fault = 1'b1;
            else begin
               ot_n = ot_ff - 1'b1;
               if (oy_ff == 0) next = opu[PcW-1:0];
            end
         end
         KIND_SIO: begin
            if (opu == SIO_WRITE) begin
               if (!has1) fault = 1'b1;
               else begin wvalid = 1'b1; wval = oy_ff; ot_n = ot_ff - 1'b1; end
            end else if (opu == SIO_READ) begin
               if (!room) fault = 1'b1;
               else begin o_we = 1'b1; o_wd = req_ff.read_value; ot_n = ot_ff + 1'b1; end
            end else if (opu == SIO_HALT) halt_n = 1'b1;
            else fault = 1'b1;
         end
         default: fault = 1'b1;
      endcase
   end

   assign pc_in = fault ? pc_ff : next;

   // call frame word writes
   logic [DaW-1:0] cwa;
   logic [31:0]    cwd;
   always_comb begin
      cwa = DaW'(sp_ff + 1'b1 + cstep_ff);
      case (cstep_ff)
         2'd0:    cwd = {{(32-DaW){1'b0}}, base_ff};
         2'd1:    cwd = {{(32-DaW){1'b0}}, bp_ff};
         default: cwd = {{(32-PcW){1'b0}}, PcW'(pc_ff + 1'b1)};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) dmem[clr_ff] <= '0;
      else if (cmd.call_step) dmem[cwa] <= cwd;
      else if (cmd.exec && !fault && d_we) dmem[d_wa] <= d_wd;
      if (cmd.exec && !fault && o_we) omem[o_wa] <= o_wd;
   end

   // halted words report the unchanged program counter
   rsp_type res_fix;
   always_comb begin
      res_fix = res_ff;
      if (halt_ff && res_ff.status == STATUS_FAULT)
         res_fix = '{next_address: 8'(pc_ff), write_valid: 1'b0,
                     write_value: '0, status: STATUS_HALT};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         bp_ff     <= '0;
         sp_ff     <= '1;
         ot_ff     <= '0;
         halt_ff   <= 1'b0;
         clr_ff    <= '0;
         rvalid_ff <= 1'b0;
         out_ff    <= '0;
         cstep_ff  <= '0;
         dcnt_ff   <= '0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.load) begin
            req_ff   <= req_data;
            hops_ff  <= req_data.level;
            base_ff  <= bp_ff;
            bad_ff   <= 1'b0;
            res_ff   <= '{next_address: 8'(pc_ff), write_valid: 1'b0,
                          write_value: '0, status: STATUS_FAULT};
            cstep_ff <= '0;
         end
         if (cmd.walk_use) begin
            if ($signed(drd_ff) < 0 || $signed(drd_ff) >= DataDepth) bad_ff <= 1'b1;
            else base_ff <= drd_ff[DaW-1:0];
            hops_ff <= hops_ff - 1'b1;
         end
         if (cmd.div_start) begin
            dneg_ff <= ox_ff[31] ^ oy_ff[31];
            dd_ff   <= oy_ff[31] ? 0 - oy_ff : oy_ff;
            dq_ff   <= ox_ff[31] ? 0 - ox_ff : ox_ff;
            dr_ff   <= '0;
            dcnt_ff <= 6'd32;
         end
         if (cmd.div_step) begin
            if ({dr_ff[30:0], dq_ff[31]} >= dd_ff || dr_ff[31]) begin
               dr_ff <= {dr_ff[30:0], dq_ff[31]} - dd_ff;
               dq_ff <= {dq_ff[30:0], 1'b1};
            end else begin
               dr_ff <= {dr_ff[30:0], dq_ff[31]};
               dq_ff <= {dq_ff[30:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         if (cmd.call_step) begin
            cstep_ff <= cstep_ff + 1'b1;
            if (cstep_ff == 2'd2) begin
               bp_ff <= DaW'(sp_ff + 1'b1);
               pc_ff <= opu[PcW-1:0];
               res_ff <= '{next_address: 8'(opu[PcW-1:0]), write_valid: 1'b0,
                           write_value: '0, status: STATUS_RUN};
            end
         end
         if (cmd.exec) begin
            pc_ff <= pc_in;
            if (!fault) begin
               bp_ff   <= bp_n;
               sp_ff   <= sp_n;
               ot_ff   <= ot_n;
               halt_ff <= halt_n;
               res_ff  <= '{next_address: 8'(next), write_valid: wvalid,
                            write_value: wval,
                            status: halt_n ? STATUS_HALT : STATUS_RUN};
            end
         end
         if (cmd.out_load) begin
            rvalid_ff <= 1'b1;
            out_ff    <= res_fix;
         end else if (rsp_ready) rvalid_ff <= 1'b0;
      end
   end

   assign rsp_data  = out_ff;
   assign rsp_valid = rvalid_ff;

   always_comb begin
      sts.clr_done  = clr_ff == DaW'(DataDepth - 1);
      sts.halted    = halt_ff;
      sts.need_walk = (kind == KIND_LOD || kind == KIND_STO || kind == KIND_CAL)
                      && hops_ff != 0;
      sts.walk_last = hops_ff == 3'd1;
      sts.walk_bad  = $signed(drd_ff) < 0 || $signed(drd_ff) >= DataDepth;
      sts.is_div    = is_opr && opu == OPR_DIV && has2 && oy_ff != 0;
      sts.is_call   = kind == KIND_CAL && call_ok;
      sts.div_done  = dcnt_ff == 6'd1;
      sts.call_done = cstep_ff == 2'd2;
   end

`include "stack_machine_instruction_executor_assert.svh"
   `SMX_ASSERT_IMP(a_ot_range, clock, reset, 1'b1, ot_ff <= OperandDepth, "operand top overflow")
   `SMX_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff, "halt cleared")
   `SMX_ASSERT_IMP(a_div_nonzero, clock, reset, cmd.div_start, oy_ff != 0, "divide by zero started")
endmodule

### rtl/core/stack_machine_instruction_executor.sv
// Stack machine executor: one instruction word in on req_, one result word
// out on rsp_, both valid/ready. req_ready is high only while the controller
// is idle; one word is worked on at a time.
// Each word passes decode, then per static link hop a walk read, wait and
// use (one data-stack read each), then an operand read and wait, then
// execute; divide first iterates one quotient bit per cycle, and call
// replaces execute by writing three frame words one per cycle through the
// single data-stack write port. The next word is taken in the cycle after
// the result is loaded.
// The result sits in an output register; while rsp_ready is low the block
// still takes and works on the next word, then holds that result until the
// output register frees, and takes no further word meanwhile.
// After reset the data stack is cleared one word per cycle before
// req_ready first rises. Once halted, every word returns status halted
// with the program counter unchanged, straight after decode.
module stack_machine_instruction_executor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  smx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output smx_pkg::rsp_type rsp_data
);
   import smx_pkg::*;

   cmd_type cmd;
   sts_type sts;

   smx_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   smx_path u_path (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
